### rtl/core/fwpid_pkg.sv
package fwpid_pkg;

   localparam int unsigned WHEELS = 4;

   localparam int unsigned VEL_W  = 16;
   localparam int unsigned TGT_W  = 18;
   localparam int unsigned ERR_W  = 19;
   localparam int unsigned DIFF_W = 20;
   localparam int unsigned GAIN_W = 16;
   localparam int unsigned LIM_W  = 15;
   localparam int unsigned FRAC_W = 8;

   // pipeline depth from accept to result register
   localparam int unsigned STAGES = 6;

   // config register indexes
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_LIMIT = 8'd3;

   localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 16'd38400;
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RST  = 16'd5120;
   localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = 16'd0;
   localparam logic [LIM_W-1:0]  DRIVE_LIMIT_RST = 15'd25000;

   // per wheel patterns, bit i is wheel i+1
   localparam logic [WHEELS-1:0] MIX_X_NEG = 4'b1010;
   localparam logic [WHEELS-1:0] MIX_Z_NEG = 4'b1100;
   localparam logic [WHEELS-1:0] POS_DIR   = 4'b1001;

   typedef struct packed {
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic signed [VEL_W-1:0] vel_z;
      logic signed [VEL_W-1:0] speed_w1;
      logic signed [VEL_W-1:0] speed_w2;
      logic signed [VEL_W-1:0] speed_w3;
      logic signed [VEL_W-1:0] speed_w4;
   } req_payload_type;

   typedef struct packed {
      logic [LIM_W-1:0] mag_w1;
      logic             dir_w1;
      logic [LIM_W-1:0] mag_w2;
      logic             dir_w2;
      logic [LIM_W-1:0] mag_w3;
      logic             dir_w3;
      logic [LIM_W-1:0] mag_w4;
      logic             dir_w4;
   } rsp_payload_type;

   typedef struct packed {
      logic [GAIN_W-1:0] prop_gain;
      logic [GAIN_W-1:0] integ_gain;
      logic [GAIN_W-1:0] deriv_gain;
      logic [LIM_W-1:0]  drive_limit;
   } cfg_type;

   // load enables for the lane stages
   typedef struct packed {
      logic ld_mul;
      logic ld_acc;
      logic ld_quo;
      logic ld_out;
   } lane_ctrl_type;

endpackage

### rtl/core/fwpid_ram.sv
module fwpid_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read during write returns the old contents
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/fwpid_err.sv
module fwpid_err import fwpid_pkg::*; #(
   parameter int unsigned SUM_WIDTH = 32
) (
   input  logic signed [VEL_W-1:0]     vel_x,
   input  logic signed [VEL_W-1:0]     vel_y,
   input  logic signed [VEL_W-1:0]     vel_z,
   input  logic signed [VEL_W-1:0]     speed,
   input  logic                        x_neg,
   input  logic                        z_neg,
   input  logic signed [SUM_WIDTH-1:0] sum_old,
   input  logic signed [ERR_W-1:0]     prev_old,
   output logic signed [ERR_W-1:0]     err,
   output logic signed [SUM_WIDTH-1:0] sum_new,
   output logic signed [DIFF_W-1:0]    diff
);

   logic signed [TGT_W-1:0]   x_ext;
   logic signed [TGT_W-1:0]   z_ext;
   logic signed [TGT_W-1:0]   x_term;
   logic signed [TGT_W-1:0]   z_term;
   logic signed [TGT_W-1:0]   target;
   logic signed [SUM_WIDTH:0] sum_wide;

   // mecanum mixing
   assign x_ext  = TGT_W'(vel_x);
   assign z_ext  = TGT_W'(vel_z);
   assign x_term = x_neg ? -x_ext : x_ext;
   assign z_term = z_neg ? -z_ext : z_ext;
   assign target = TGT_W'(vel_y) + x_term + z_term;

   assign err      = ERR_W'(target) - ERR_W'(speed);
   assign diff     = DIFF_W'(err) - DIFF_W'(prev_old);
   assign sum_wide = (SUM_WIDTH+1)'(sum_old) + (SUM_WIDTH+1)'(err);

   // saturate the running sum
   always_comb begin
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
         sum_new = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                       : {1'b0, {(SUM_WIDTH-1){1'b1}}};
      end else begin
         sum_new = sum_wide[SUM_WIDTH-1:0];
      end
   end

endmodule

### rtl/core/fwpid_lane.sv
module fwpid_lane import fwpid_pkg::*; #(
   parameter int unsigned SUM_WIDTH = 32
) (
   input  logic                        clock,
   input  lane_ctrl_type               ctrl,
   input  cfg_type                     cfg,
   input  logic                        pos_dir,
   input  logic signed [ERR_W-1:0]     err,
   input  logic signed [SUM_WIDTH-1:0] sum,
   input  logic signed [DIFF_W-1:0]    diff,
   output logic [LIM_W-1:0]            mag,
   output logic                        dir
);

   localparam int unsigned P_W   = GAIN_W + 1 + ERR_W;
   localparam int unsigned I_W   = GAIN_W + 1 + SUM_WIDTH;
   localparam int unsigned D_W   = GAIN_W + 1 + DIFF_W;
   localparam int unsigned ACC_W = SUM_WIDTH + GAIN_W + 3;
   localparam int unsigned Q_W   = ACC_W - FRAC_W;

   logic signed [GAIN_W:0]  kp_s;
   logic signed [GAIN_W:0]  ki_s;
   logic signed [GAIN_W:0]  kd_s;
   logic signed [P_W-1:0]   p_in,  p_ff;
   logic signed [I_W-1:0]   i_in,  i_ff;
   logic signed [D_W-1:0]   d_in,  d_ff;
   logic signed [ACC_W-1:0] acc_in, acc_ff;
   logic signed [Q_W-1:0]   q_in,  q_ff;
   logic                    round_up;
   logic                    q_neg;
   logic [Q_W-1:0]          q_abs;
   logic                    over;
   logic [LIM_W-1:0]        mag_in, mag_ff;
   logic                    dir_in, dir_ff;

   assign kp_s = $signed({1'b0, cfg.prop_gain});
   assign ki_s = $signed({1'b0, cfg.integ_gain});
   assign kd_s = $signed({1'b0, cfg.deriv_gain});

   assign p_in = kp_s * err;
   assign i_in = ki_s * sum;
   assign d_in = kd_s * diff;

   assign acc_in = ACC_W'(p_ff) + ACC_W'(i_ff) + ACC_W'(d_ff);

   // divide by 256 toward zero
   assign round_up = acc_ff[ACC_W-1] && (acc_ff[FRAC_W-1:0] != '0);
   assign q_in     = acc_ff[ACC_W-1:FRAC_W] + Q_W'(round_up);

   // symmetric clamp, a duty clamped to zero counts as non-negative
   assign q_neg  = q_ff[Q_W-1];
   assign q_abs  = q_neg ? -q_ff : q_ff;
   assign over   = q_abs > Q_W'(cfg.drive_limit);
   assign mag_in = over ? cfg.drive_limit : q_abs[LIM_W-1:0];
   assign dir_in = pos_dir ^ (q_neg && (cfg.drive_limit != '0));

   always_ff @(posedge clock) begin
      if (ctrl.ld_mul) begin
         p_ff <= p_in;
         i_ff <= i_in;
         d_ff <= d_in;
      end
      if (ctrl.ld_acc) begin
         acc_ff <= acc_in;
      end
      if (ctrl.ld_quo) begin
         q_ff <= q_in;
      end
      if (ctrl.ld_out) begin
         mag_ff <= mag_in;
         dir_ff <= dir_in;
      end
   end

   assign mag = mag_ff;
   assign dir = dir_ff;

endmodule

### rtl/core/four_wheel_pid_speed_control.sv
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+----------------------------------
// req      | in        | req_valid/req_stall  | req_data: velocity cmd, 4 speeds
// rsp      | out       | rsp_valid/rsp_stall  | rsp_data: magnitude, dir per wheel
// csr      | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// one transaction per cycle sustained while rsp_stall is low; each result is valid
// in the sixth stage after its request is taken, set by the state read, the error
// update, two multiply/add levels and the divide/clamp steps
// the error sums and last errors sit in two one-row rams; the row written by
// one transaction is forwarded to the next when its read hits the same edge
// reset is synchronous; the state row reads as zero until first written
// stages advance independently, so bubbles collapse and rsp_stall only
// backs up into req_stall once every stage is full
module four_wheel_pid_speed_control import fwpid_pkg::*; #(
   parameter int unsigned SUM_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int unsigned SUM_ROW_W  = WHEELS * SUM_WIDTH;
   localparam int unsigned PREV_ROW_W = WHEELS * ERR_W;
   localparam logic [0:0]  ROW_ADDR   = 1'b0;

   // configuration registers
   cfg_type cfg_ff;

   // pipeline valids, bit 0 is the request stage, the top bit the result
   logic [STAGES-1:0] vld_ff, vld_in;
   logic [STAGES-1:0] ready;
   logic              accept;
   logic              wr_en;

   // request stage payload
   req_payload_type in_ff;

   // state row bookkeeping
   logic                  row_valid_ff;
   logic                  rd_ok_ff;
   logic                  fwd_ff;
   logic [SUM_ROW_W-1:0]  fwd_sum_ff;
   logic [PREV_ROW_W-1:0] fwd_prev_ff;
   logic [SUM_ROW_W-1:0]  sum_q, sum_wr;
   logic [PREV_ROW_W-1:0] prev_q, prev_wr;

   logic signed [VEL_W-1:0] speed [WHEELS];

   // error stage registers
   logic signed [ERR_W-1:0]     err_ff  [WHEELS];
   logic signed [SUM_WIDTH-1:0] sum_ff  [WHEELS];
   logic signed [DIFF_W-1:0]    diff_ff [WHEELS];

   lane_ctrl_type    lane_ctrl;
   logic [LIM_W-1:0] mag [WHEELS];
   logic             dir [WHEELS];

   // ---------------------------------------------------------------
   // csr write port, always ready; unknown indexes are dropped
   // ---------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain   <= PROP_GAIN_RST;
         cfg_ff.integ_gain  <= INTEG_GAIN_RST;
         cfg_ff.deriv_gain  <= DERIV_GAIN_RST;
         cfg_ff.drive_limit <= DRIVE_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PROP_GAIN:   cfg_ff.prop_gain   <= csr_data;
            CSR_INTEG_GAIN:  cfg_ff.integ_gain  <= csr_data;
            CSR_DERIV_GAIN:  cfg_ff.deriv_gain  <= csr_data;
            CSR_DRIVE_LIMIT: cfg_ff.drive_limit <= csr_data[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // pipeline flow control: a stage takes new data when empty or when
   // its occupant moves on
   // ---------------------------------------------------------------
   always_comb begin
      ready[STAGES-1] = !vld_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         ready[k] = !vld_ff[k] || ready[k+1];
      end
   end

   always_comb begin
      vld_in[0] = ready[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = ready[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign accept    = req_valid && ready[0];
   assign req_stall = !ready[0];
   // state row is written back as the request stage moves to the error stage
   assign wr_en     = vld_ff[0] && ready[1];

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
   end

   // ---------------------------------------------------------------
   // state rams, read on accept, written back one stage later
   // ---------------------------------------------------------------
   fwpid_ram #(
      .WIDTH (SUM_ROW_W),
      .DEPTH (1)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ROW_ADDR),
      .wr_data (sum_wr),
      .rd_en   (accept),
      .rd_addr (ROW_ADDR),
      .rd_data (sum_q)
   );

   fwpid_ram #(
      .WIDTH (PREV_ROW_W),
      .DEPTH (1)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ROW_ADDR),
      .wr_data (prev_wr),
      .rd_en   (accept),
      .rd_addr (ROW_ADDR),
      .rd_data (prev_q)
   );

   // row valid flag stands in for clearing the rams at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= 1'b0;
         rd_ok_ff     <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff <= 1'b1;
         end
         if (accept) begin
            rd_ok_ff <= row_valid_ff;
            // an occupied request stage always writes back on this edge,
            // so the ram read missed that write
            fwd_ff   <= vld_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_sum_ff  <= sum_wr;
         fwd_prev_ff <= prev_wr;
      end
   end

   assign speed[0] = in_ff.speed_w1;
   assign speed[1] = in_ff.speed_w2;
   assign speed[2] = in_ff.speed_w3;
   assign speed[3] = in_ff.speed_w4;

   // lane stage enables
   assign lane_ctrl.ld_mul = ready[2];
   assign lane_ctrl.ld_acc = ready[3];
   assign lane_ctrl.ld_quo = ready[4];
   assign lane_ctrl.ld_out = ready[5];

   // ---------------------------------------------------------------
   // per wheel: error update, then gains, sum, divide and clamp
   // ---------------------------------------------------------------
   for (genvar w = 0; w < WHEELS; w++) begin : g_wheel
      logic signed [SUM_WIDTH-1:0] sum_old;
      logic signed [ERR_W-1:0]     prev_old;
      logic signed [ERR_W-1:0]     err_new;
      logic signed [SUM_WIDTH-1:0] sum_new;
      logic signed [DIFF_W-1:0]    diff_new;

      // forwarded row, then ram row, then the reset value
      always_comb begin
         priority if (fwd_ff) begin
            sum_old  = fwd_sum_ff[w*SUM_WIDTH +: SUM_WIDTH];
            prev_old = fwd_prev_ff[w*ERR_W +: ERR_W];
         end else if (rd_ok_ff) begin
            sum_old  = sum_q[w*SUM_WIDTH +: SUM_WIDTH];
            prev_old = prev_q[w*ERR_W +: ERR_W];
         end else begin
            sum_old  = '0;
            prev_old = '0;
         end
      end

      fwpid_err #(
         .SUM_WIDTH (SUM_WIDTH)
      ) u_err (
         .vel_x    (in_ff.vel_x),
         .vel_y    (in_ff.vel_y),
         .vel_z    (in_ff.vel_z),
         .speed    (speed[w]),
         .x_neg    (MIX_X_NEG[w]),
         .z_neg    (MIX_Z_NEG[w]),
         .sum_old  (sum_old),
         .prev_old (prev_old),
         .err      (err_new),
         .sum_new  (sum_new),
         .diff     (diff_new)
      );

      assign sum_wr[w*SUM_WIDTH +: SUM_WIDTH] = sum_new;
      assign prev_wr[w*ERR_W +: ERR_W]        = err_new;

      always_ff @(posedge clock) begin
         if (ready[1]) begin
            err_ff[w]  <= err_new;
            sum_ff[w]  <= sum_new;
            diff_ff[w] <= diff_new;
         end
      end

      fwpid_lane #(
         .SUM_WIDTH (SUM_WIDTH)
      ) u_lane (
         .clock   (clock),
         .ctrl    (lane_ctrl),
         .cfg     (cfg_ff),
         .pos_dir (POS_DIR[w]),
         .err     (err_ff[w]),
         .sum     (sum_ff[w]),
         .diff    (diff_ff[w]),
         .mag     (mag[w]),
         .dir     (dir[w])
      );
   end

   // ---------------------------------------------------------------
   // result transaction
   // ---------------------------------------------------------------
   assign rsp_valid       = vld_ff[STAGES-1];
   assign rsp_data.mag_w1 = mag[0];
   assign rsp_data.dir_w1 = dir[0];
   assign rsp_data.mag_w2 = mag[1];
   assign rsp_data.dir_w2 = dir[1];
   assign rsp_data.mag_w3 = mag[2];
   assign rsp_data.dir_w3 = dir[2];
   assign rsp_data.mag_w4 = mag[3];
   assign rsp_data.dir_w4 = dir[3];

endmodule

### sim/wheel_duty_checker.sv
`timescale 1ns / 100ps
module wheel_duty_checker import fwpid_pkg::*; #(
   parameter int unsigned SUM_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_payload_type       req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_payload_type       rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    mismatches,
   output int                    outstanding
);

   // bit w belongs to wheel w+1
   localparam bit [3:0] X_NEG        = 4'b1010;
   localparam bit [3:0] Z_NEG        = 4'b1100;
   localparam bit [3:0] FWD_POLARITY = 4'b1001;
   localparam int       PRINT_LIMIT  = 40;

   bit [15:0] kp;
   bit [15:0] ki;
   bit [15:0] kd;
   bit [14:0] duty_limit;
   longint    err_sum [4];
   longint    last_err [4];

   rsp_payload_type expected_duty [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT) begin
         $display("mismatch at %0t: %s", $time, msg);
      end
      mismatches++;
   endtask

   function automatic rsp_payload_type predict_drive(input req_payload_type cmd);
      longint          speed [4];
      longint          target;
      longint          err;
      longint          acc;
      longint          duty;
      longint          sum_hi;
      longint          sum_lo;
      longint          lim;
      bit [14:0]       mag [4];
      bit              dir [4];
      int              w;
      rsp_payload_type res;
      sum_hi   = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
      sum_lo   = -sum_hi - 1;
      lim      = longint'(duty_limit);
      speed[0] = longint'(cmd.speed_w1);
      speed[1] = longint'(cmd.speed_w2);
      speed[2] = longint'(cmd.speed_w3);
      speed[3] = longint'(cmd.speed_w4);
      for (w = 0; w < 4; w++) begin
         target = longint'(cmd.vel_y)
                + (X_NEG[w] ? -longint'(cmd.vel_x) : longint'(cmd.vel_x))
                + (Z_NEG[w] ? -longint'(cmd.vel_z) : longint'(cmd.vel_z));
         err = target - speed[w];
         err_sum[w] = err_sum[w] + err;
         if (err_sum[w] > sum_hi) err_sum[w] = sum_hi;
         if (err_sum[w] < sum_lo) err_sum[w] = sum_lo;
         acc = longint'(kp) * err + longint'(ki) * err_sum[w]
             + longint'(kd) * (err - last_err[w]);
         last_err[w] = err;
         duty = acc / 256;
         if (duty > lim) duty = lim;
         if (duty < -lim) duty = -lim;
         if (duty >= 0) begin
            mag[w] = 15'(duty);
            dir[w] = FWD_POLARITY[w];
         end else begin
            mag[w] = 15'(-duty);
            dir[w] = !FWD_POLARITY[w];
         end
      end
      res.mag_w1 = mag[0];
      res.dir_w1 = dir[0];
      res.mag_w2 = mag[1];
      res.dir_w2 = dir[1];
      res.mag_w3 = mag[2];
      res.dir_w3 = dir[2];
      res.mag_w4 = mag[3];
      res.dir_w4 = dir[3];
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      logic [63:0]     got_bits;
      logic [63:0]     want_bits;
      int              w;
      if (reset) begin
         kp         = PROP_GAIN_RST;
         ki         = INTEG_GAIN_RST;
         kd         = DERIV_GAIN_RST;
         duty_limit = DRIVE_LIMIT_RST;
         for (w = 0; w < 4; w++) begin
            err_sum[w]  = 0;
            last_err[w] = 0;
         end
         expected_duty.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PROP_GAIN:   kp = csr_data;
               CSR_INTEG_GAIN:  ki = csr_data;
               CSR_DERIV_GAIN:  kd = csr_data;
               CSR_DRIVE_LIMIT: duty_limit = csr_data[14:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_duty.push_back(predict_drive(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_duty.size() == 0) begin
               report_mismatch($sformatf("result %h with nothing expected", rsp_data));
            end else begin
               want      = expected_duty.pop_front();
               got_bits  = rsp_data;
               want_bits = want;
               for (w = 0; w < 4; w++) begin
                  if (got_bits[63-16*w -: 15] !== want_bits[63-16*w -: 15]) begin
                     report_mismatch($sformatf("mag_w%0d got %0d expected %0d", w + 1,
                        got_bits[63-16*w -: 15], want_bits[63-16*w -: 15]));
                  end
                  if (got_bits[48-16*w] !== want_bits[48-16*w]) begin
                     report_mismatch($sformatf("dir_w%0d got %b expected %b", w + 1,
                        got_bits[48-16*w], want_bits[48-16*w]));
                  end
               end
            end
         end
      end
      outstanding <= expected_duty.size();
   end

endmodule

### sim/four_wheel_pid_speed_control_tb.sv
`timescale 1ns / 100ps
module four_wheel_pid_speed_control_tb;
   import fwpid_pkg::*;

   // cycles with no transaction on any channel before the run is called hung
   localparam int WATCHDOG_LIMIT = 2000;
   // extra cycles after the last result, pipeline is six deep
   localparam int DRAIN_CYCLES   = 12;
   // max-error ticks in the first and last legs of the integral ramp, twice that in the middle
   localparam int SOAK_TICKS     = 10;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   int mismatches;
   int outstanding;
   int quiet_cycles = 0;
   // when set, neither side idles
   bit calm = 1'b0;

   always #5 clock = ~clock;

   four_wheel_pid_speed_control uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // predicts every transaction and compares the duty results
   wheel_duty_checker duty_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // receiver back-pressure at random, none while calm is set
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 11);
   end

   // watchdog: any accepted transaction restarts the count
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("four_wheel_pid_speed_control_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // build a command from integers, each truncated to 16 bits
   function automatic req_payload_type make_cmd(input int x, input int y, input int z,
                                                input int s1, input int s2,
                                                input int s3, input int s4);
      req_payload_type c;
      c.vel_x    = 16'(x);
      c.vel_y    = 16'(y);
      c.vel_z    = 16'(z);
      c.speed_w1 = 16'(s1);
      c.speed_w2 = 16'(s2);
      c.speed_w3 = 16'(s3);
      c.speed_w4 = 16'(s4);
      return c;
   endfunction

   // mix of full range, near zero, rail values and speeds tracking the targets
   function automatic req_payload_type random_cmd();
      int f [7];
      int kind;
      int i;
      kind = $urandom_range(99);
      for (i = 0; i < 7; i++) begin
         if (kind < 30) begin
            f[i] = $urandom;
         end else if (kind < 65) begin
            f[i] = int'($urandom_range(600)) - 300;
         end else begin
            case ($urandom_range(4))
               0: f[i] = 32767;
               1: f[i] = -32768;
               2: f[i] = 0;
               3: f[i] = -1;
               default: f[i] = 1;
            endcase
         end
      end
      // closed loop: wheel speeds sit close to the mixed targets
      if (kind >= 80) begin
         for (i = 0; i < 3; i++) f[i] = int'($urandom_range(6000)) - 3000;
         f[3] = f[1] + f[0] + f[2] + int'($urandom_range(40)) - 20;
         f[4] = f[1] - f[0] + f[2] + int'($urandom_range(40)) - 20;
         f[5] = f[1] + f[0] - f[2] + int'($urandom_range(40)) - 20;
         f[6] = f[1] - f[0] - f[2] + int'($urandom_range(40)) - 20;
      end
      return make_cmd(f[0], f[1], f[2], f[3], f[4], f[5], f[6]);
   endfunction

   // one request transaction, with random idle cycles in front
   task automatic send_cmd(input req_payload_type cmd);
      while (!calm && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      do @(posedge clock); while (req_stall);
   endtask

   // stop sending and wait until every expected result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   // csr_valid stays high across back to back writes
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // new gain set while idle, with writes to unmapped indexes around it
   task automatic set_gains(input logic [15:0] p, input logic [15:0] i,
                            input logic [15:0] d, input logic [15:0] lim);
      wait_drained();
      write_reg(8'($urandom_range(4, 255)), 16'($urandom));
      write_reg(CSR_PROP_GAIN, p);
      write_reg(CSR_INTEG_GAIN, i);
      write_reg(CSR_DERIV_GAIN, d);
      write_reg(CSR_DRIVE_LIMIT, lim);
      write_reg(8'($urandom_range(4, 255)), 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int n);
      repeat (n) send_cmd(random_cmd());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed commands under the reset gains
      send_cmd(make_cmd(0, 0, 0, 0, 0, 0, 0));                  // zero duty
      send_cmd(make_cmd(0, 1, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(0, -1, 0, 0, 0, 0, 0));                 // negative duty
      send_cmd(make_cmd(32767, 32767, 32767, 32767, 32767, 32767, 32767));
      send_cmd(make_cmd(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
      send_cmd(make_cmd(32767, 32767, 32767, -32768, -32768, -32768, -32768));
      send_cmd(make_cmd(-32768, -32768, -32768, 32767, 32767, 32767, 32767));
      send_cmd(make_cmd(32767, 0, 0, 0, 0, 0, 0));              // sideways only
      send_cmd(make_cmd(0, 0, -32768, 0, 0, 0, 0));             // rotation only
      send_cmd(make_cmd(100, 200, 300, 600, 400, 0, -200));     // zero error

      // unit gain, checks truncation toward zero
      set_gains(16'd1, 16'd0, 16'd0, 16'd32767);
      send_cmd(make_cmd(0, -1, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(0, -255, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(0, -256, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(0, -257, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(0, 255, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(0, 257, 0, 0, 0, 0, 0));

      // zero limit forces zero magnitude and forward polarity
      set_gains(PROP_GAIN_RST, INTEG_GAIN_RST, 16'd0, 16'd0);
      send_cmd(make_cmd(32767, 32767, 32767, -32768, -32768, -32768, -32768));
      send_cmd(make_cmd(-32768, -32768, -32768, 32767, 32767, 32767, 32767));
      send_cmd(make_cmd(0, -5, 0, 0, 0, 0, 0));

      // long stretch with no idling on either side
      calm = 1'b1;
      set_gains(16'd256, 16'd0, 16'd0, 16'd32767);
      run_random(100);
      calm = 1'b0;

      // all gains at the top, limit write with bit 15 set is masked
      set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random(100);

      set_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'd0);
      run_random(50);

      repeat (4) begin
         set_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         run_random(50);
      end

      set_gains(16'd1, 16'd1, 16'hFFFF, 16'd1);
      run_random(50);

      // integral ramp: push the error sum up, down past its starting value, then back to it;
      // a tiny integral gain shows the crossing
      set_gains(16'd0, 16'd1, 16'd0, 16'd32767);
      repeat (SOAK_TICKS) send_cmd(make_cmd(0, 32767, 0, -32768, -32768, -32768, -32768));
      repeat (2 * SOAK_TICKS) send_cmd(make_cmd(0, -32768, 0, 32767, 32767, 32767, 32767));
      repeat (SOAK_TICKS) send_cmd(make_cmd(0, 32767, 0, -32768, -32768, -32768, -32768));

      set_gains(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, 16'(DRIVE_LIMIT_RST));
      run_random(80);

      // drain, then watch a little longer for stray results
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("four_wheel_pid_speed_control_tb passed");
      end else begin
         $display("four_wheel_pid_speed_control_tb failed");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/fwpid_pkg.sv
rtl/core/fwpid_ram.sv
rtl/core/fwpid_err.sv
rtl/core/fwpid_lane.sv
rtl/core/four_wheel_pid_speed_control.sv
sim/wheel_duty_checker.sv
sim/four_wheel_pid_speed_control_tb.sv
